>>> design/stun_attribute_address_extract_top_assert.svh
// Assertion macros shared by the checker file.
`ifndef STUN_ATTRIBUTE_ADDRESS_EXTRACT_TOP_ASSERT_SVH
`define STUN_ATTRIBUTE_ADDRESS_EXTRACT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STAAE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define STAAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next-cycle check");

`endif

>>> design/staae_pkg.sv
package staae_pkg;

    // Default width of the saturating byte position counter.
    localparam int POSITION_BITS = 16;

    // Message and attribute layout.
    localparam int MSG_HEADER_BYTES = 20;
    localparam logic [15:0] ATTR_HEADER_BYTES = 16'd4;
    localparam logic [15:0] ADDR_VALUE_BYTES = 16'd8;
    localparam logic [7:0] FAMILY_IPV4 = 8'd1;

    // Reset value of the wanted attribute type register.
    localparam logic [15:0] WANTED_TYPE_RESET = 16'd1;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_MSG_HDR  = 2'd0,
        PH_ATTR_HDR = 2'd1,
        PH_VALUE    = 2'd2,
        PH_DONE     = 2'd3
    } phase_t;

    // Result of one message.
    typedef struct packed {
        logic        found;
        logic [15:0] port;
        logic [31:0] addr;
    } result_t;

endpackage

>>> design/staae_parser.sv
module staae_parser #(
    parameter int POSITION_BITS = staae_pkg::POSITION_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          msg_byte,
    input  logic                msg_last,
    input  logic [15:0]         wanted_type,
    output staae_pkg::result_t  result
);

    localparam logic [POSITION_BITS-1:0] HDR_LAST_POS =
        POSITION_BITS'(staae_pkg::MSG_HEADER_BYTES - 1);

    staae_pkg::phase_t          phase_reg, phase_upd, phase_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_upd, pos_next;
    logic [23:0]                hdr_reg, hdr_upd, hdr_next;
    logic [15:0]                left_reg, left_upd, left_next;
    logic                       matched_reg, matched_upd, matched_next;
    logic                       found_reg, found_upd, found_next;
    logic [55:0]                capture_reg, capture_upd, capture_next;

    logic [31:0]                new_hdr;
    logic [15:0]                left_dec;
    logic [15:0]                attr_len;

    assign new_hdr  = {hdr_reg, msg_byte};
    assign attr_len = new_hdr[15:0];
    assign left_dec = (left_reg != 16'd0) ? (left_reg - 16'd1) : left_reg;

    // Next state for one byte, before the end-of-message clear.
    always_comb
    begin
        phase_upd   = phase_reg;
        pos_upd     = pos_reg;
        hdr_upd     = hdr_reg;
        left_upd    = left_reg;
        matched_upd = matched_reg;
        found_upd   = found_reg;
        capture_upd = capture_reg;
        case (phase_reg)
            staae_pkg::PH_MSG_HDR:
            begin
                if (pos_reg >= HDR_LAST_POS)
                begin
                    phase_upd = staae_pkg::PH_ATTR_HDR;
                    left_upd  = staae_pkg::ATTR_HEADER_BYTES;
                end
            end
            staae_pkg::PH_ATTR_HDR:
            begin
                hdr_upd  = new_hdr[23:0];
                left_upd = left_dec;
                if (left_dec == 16'd0)
                begin
                    matched_upd = (new_hdr[31:16] == wanted_type);
                    if (matched_upd && (attr_len != staae_pkg::ADDR_VALUE_BYTES))
                    begin
                        phase_upd = staae_pkg::PH_DONE;
                        found_upd = 1'b0;
                    end
                    else if (attr_len == 16'd0)
                    begin
                        phase_upd = staae_pkg::PH_ATTR_HDR;
                        left_upd  = staae_pkg::ATTR_HEADER_BYTES;
                    end
                    else
                    begin
                        phase_upd = staae_pkg::PH_VALUE;
                        left_upd  = attr_len;
                    end
                end
            end
            staae_pkg::PH_VALUE:
            begin
                if (matched_reg)
                begin
                    capture_upd = {capture_reg[47:0], msg_byte};
                end
                left_upd = left_dec;
                if (left_dec == 16'd0)
                begin
                    if (matched_reg)
                    begin
                        phase_upd = staae_pkg::PH_DONE;
                        found_upd = (capture_upd[55:48] == staae_pkg::FAMILY_IPV4);
                    end
                    else
                    begin
                        phase_upd = staae_pkg::PH_ATTR_HDR;
                        left_upd  = staae_pkg::ATTR_HEADER_BYTES;
                    end
                end
            end
            default:
            begin
                phase_upd = phase_reg;
            end
        endcase
        if (pos_reg != {POSITION_BITS{1'b1}})
        begin
            pos_upd = pos_reg + POSITION_BITS'(1);
        end
    end

    // The final byte of a message clears the walk state.
    always_comb
    begin
        phase_next   = phase_upd;
        pos_next     = pos_upd;
        hdr_next     = hdr_upd;
        left_next    = left_upd;
        matched_next = matched_upd;
        found_next   = found_upd;
        capture_next = capture_upd;
        if (msg_last)
        begin
            phase_next   = staae_pkg::PH_MSG_HDR;
            pos_next     = '0;
            left_next    = 16'd0;
            matched_next = 1'b0;
            found_next   = 1'b0;
        end
    end

    // Result as seen after this byte; only used on the final byte.
    always_comb
    begin
        result.found = (phase_upd == staae_pkg::PH_DONE) && found_upd;
        result.port  = result.found ? capture_upd[47:32] : 16'd0;
        result.addr  = result.found ? capture_upd[31:0] : 32'd0;
    end

    // Control state of the walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= staae_pkg::PH_MSG_HDR;
            pos_reg     <= '0;
            left_reg    <= 16'd0;
            matched_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            left_reg    <= left_next;
            matched_reg <= matched_next;
            found_reg   <= found_next;
        end
    end

    // Header and value bytes; fully overwritten before use.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hdr_reg     <= hdr_next;
            capture_reg <= capture_next;
        end
    end

endmodule

>>> design/stun_attribute_address_extract_top.sv
// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+-----------------------------------
// input    | in        | in_valid / in_stall | message_byte, last_byte
// output   | out       | out_valid/out_stall | found, mapped_port, ipv4_address
// config   | in        | cfg_valid/cfg_ready | wanted_attribute_type
//
// One message byte is accepted every clock cycle while in_stall is low.
// After the final byte of a message is accepted, the result passes through the input
// register, then through the parser into the result register.
// Reset clears the walk state and sets the wanted type to 1.
// in_stall rises only when a final byte waits behind a stalled result word.
module stun_attribute_address_extract_top #(
    parameter int POSITION_BITS = staae_pkg::POSITION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  message_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [15:0] mapped_port,
    output logic [31:0] ipv4_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] wanted_attribute_type
);

    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         s1_byte_reg;
    logic               s1_last_reg;
    logic               out_valid_reg, out_valid_next;
    staae_pkg::result_t res_reg;
    staae_pkg::result_t parse_res;
    logic [15:0]        wanted_reg;
    logic               in_take;
    logic               out_free;
    logic               s1_adv;

    // Handshake control.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wanted_reg    <= staae_pkg::WANTED_TYPE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                wanted_reg <= wanted_attribute_type;
            end
        end
    end

    // Input word register.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= message_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Parser with its walk state.
    staae_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_adv),
        .msg_byte    (s1_byte_reg),
        .msg_last    (s1_last_reg),
        .wanted_type (wanted_reg),
        .result      (parse_res)
    );

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            res_reg <= parse_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = res_reg.found;
    assign mapped_port  = res_reg.port;
    assign ipv4_address = res_reg.addr;

endmodule

>>> design/staae_checker.sv
`include "stun_attribute_address_extract_top_assert.svh"

module staae_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  message_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [15:0] mapped_port,
    input logic [31:0] ipv4_address,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [15:0] wanted_attribute_type
);

    // A result word that is not found carries zero fields.
    `STAAE_ASSERT_SAME(a_zero_when_absent, clk, rst_n, out_valid && !found,
        mapped_port == 16'd0 && ipv4_address == 32'd0)

    // The input side stalls only behind a stalled result word.
    `STAAE_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A new result word follows the final byte of a message through the input and result registers.
    `STAAE_ASSERT_SAME(a_result_after_last, clk, rst_n, $rose(out_valid),
        $past(in_valid && !in_stall && last_byte, 2))

    // A stalled result word holds.
    `STAAE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(found) && $stable(mapped_port) && $stable(ipv4_address))

endmodule

bind stun_attribute_address_extract_top staae_checker u_staae_checker (.*);
